### design/dssm_pkg.sv
// shared types, codes and microprogram for the two-stack shared memory
package dssm_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_PEEK   = 1'b1;
    localparam logic SEL_LOWER  = 1'b0;
    localparam logic SEL_UPPER  = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        t_status                status;
    } t_result;

    // microprogram addresses
    typedef enum logic [3:0] {
        STEP_FETCH,
        STEP_DECODE,
        STEP_PUSH_CHECK,
        STEP_PUSH_SETUP,
        STEP_SHIFT_PRIME,
        STEP_SHIFT,
        STEP_WRITE,
        STEP_PEEK_CHECK,
        STEP_PEEK_READ,
        STEP_PEEK_DATA,
        STEP_OUTPUT
    } t_step;

    // sequencing: next step, unconditional jump, branch or wait on a condition
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_BRANCH,
        SEQ_WAIT
    } t_seq_op;

    typedef enum logic [2:0] {
        C_ACCEPT,
        C_PEEK,
        C_FULL,
        C_UPPER,
        C_AT_FIRST,
        C_SHIFT_DONE,
        C_EMPTY,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_TOTAL,
        PTR_DEC,
        PTR_TOP
    } t_ptr_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PTR,
        RD_PTR_M1,
        RD_PTR_M2
    } t_rd_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_VALUE
    } t_wr_op;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_PUSH_OK,
        RES_OVERFLOW,
        RES_EMPTY,
        RES_READ
    } t_res_op;

    typedef struct packed {
        logic    in_ready;
        t_ptr_op ptr_op;
        t_rd_op  rd_op;
        t_wr_op  wr_op;
        t_res_op res_op;
        logic    cnt_push;
        logic    out_load;
        t_seq_op seq;
        t_cond   cond;
        t_step   target;
    } t_ctl;

    typedef struct packed {
        logic accept;
        logic peek;
        logic full;
        logic upper;
        logic at_first;
        logic shift_done;
        logic empty;
        logic out_free;
    } t_flags;

    // control store
    function automatic t_ctl ucode(input t_step step);
        t_ctl c;
        c = '0;
        case (step)
            STEP_FETCH: begin
                c.in_ready = 1'b1;
                c.seq      = SEQ_WAIT;
                c.cond     = C_ACCEPT;
                c.target   = STEP_DECODE;
            end
            STEP_DECODE: begin
                c.seq    = SEQ_BRANCH;
                c.cond   = C_PEEK;
                c.target = STEP_PEEK_CHECK;
            end
            STEP_PUSH_CHECK: begin
                c.res_op = RES_OVERFLOW;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_FULL;
                c.target = STEP_OUTPUT;
            end
            STEP_PUSH_SETUP: begin
                c.ptr_op = PTR_TOTAL;
                c.res_op = RES_PUSH_OK;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_UPPER;
                c.target = STEP_WRITE;
            end
            STEP_SHIFT_PRIME: begin
                c.rd_op  = RD_PTR_M1;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_AT_FIRST;
                c.target = STEP_WRITE;
            end
            STEP_SHIFT: begin
                c.wr_op  = WR_SHIFT;
                c.rd_op  = RD_PTR_M2;
                c.ptr_op = PTR_DEC;
                c.seq    = SEQ_WAIT;
                c.cond   = C_SHIFT_DONE;
                c.target = STEP_WRITE;
            end
            STEP_WRITE: begin
                c.wr_op    = WR_VALUE;
                c.cnt_push = 1'b1;
                c.seq      = SEQ_GOTO;
                c.target   = STEP_OUTPUT;
            end
            STEP_PEEK_CHECK: begin
                c.res_op = RES_EMPTY;
                c.ptr_op = PTR_TOP;
                c.seq    = SEQ_BRANCH;
                c.cond   = C_EMPTY;
                c.target = STEP_OUTPUT;
            end
            STEP_PEEK_READ: begin
                c.rd_op = RD_PTR;
            end
            STEP_PEEK_DATA: begin
                c.res_op = RES_READ;
            end
            STEP_OUTPUT: begin
                c.out_load = 1'b1;
                c.seq      = SEQ_WAIT;
                c.cond     = C_OUT_FREE;
                c.target   = STEP_FETCH;
            end
            default: begin
                c.seq    = SEQ_GOTO;
                c.target = STEP_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

### design/dssm_if.sv
// valid/ready channel interfaces for requests and results
interface dssm_in_if import dssm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic                          stack_select;
    logic signed [VALUE_WIDTH-1:0] push_value;

    modport source (output valid, action, stack_select, push_value, input ready);
    modport sink   (input valid, action, stack_select, push_value, output ready);
endinterface

interface dssm_out_if import dssm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic [STATUS_WIDTH-1:0]       status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

### design/dual_stack_shared_memory.sv
// top level of the two-stack shared memory with its result register
//
// Two stacks live in one array of DEPTH words of DATA_WIDTH bits. The lower
// stack holds entries 0 to first-1 and the upper stack sits directly above
// it, up to total-1. Each request transaction is a push or a peek on one
// stack and yields exactly one result transaction. A push to the lower stack
// moves every upper-stack word up one slot, highest first, one word per
// cycle over the array's one write and one read port, then writes the value.
// Requests are taken one at a time; the next is accepted once the result is
// in the output register, even while that result still waits for the sink.
// No request is taken while reset is held.
// The array has no reset and needs none: peeks only reach written words.
module dual_stack_shared_memory import dssm_pkg::*; #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dssm_in_if.sink    i_in,
    dssm_out_if.source o_out
);

    t_ctl    ctl;
    t_flags  flags;
    t_result result;

    // output register, parts the sequencer from the sink
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    out_load;

    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ctl.out_load && out_free;

    // request side only opens in the fetch step and out of reset
    assign i_in.ready = ctl.in_ready && i_rst_n;

    dssm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    dssm_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_in_valid     (i_in.valid),
        .i_action       (i_in.action),
        .i_stack_select (i_in.stack_select),
        .i_push_value   (i_in.push_value),
        .i_out_free     (out_free),
        .o_flags        (flags),
        .o_result       (result)
    );

    // result transaction held until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out.value;
    assign o_out.status     = r_out.status;

endmodule

### design/dssm_seq.sv
// microcode sequencer: step counter, control store and condition select
module dssm_seq import dssm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    t_step r_step;
    t_step n_step;
    t_ctl  ctl;
    logic  cond_true;

    always_comb begin
        ctl = ucode(r_step);
    end

    always_comb begin
        case (ctl.cond)
            C_ACCEPT:     cond_true = i_flags.accept;
            C_PEEK:       cond_true = i_flags.peek;
            C_FULL:       cond_true = i_flags.full;
            C_UPPER:      cond_true = i_flags.upper;
            C_AT_FIRST:   cond_true = i_flags.at_first;
            C_SHIFT_DONE: cond_true = i_flags.shift_done;
            C_EMPTY:      cond_true = i_flags.empty;
            C_OUT_FREE:   cond_true = i_flags.out_free;
            default:      cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        case (ctl.seq)
            SEQ_NEXT:   n_step = t_step'(r_step + 4'd1);
            SEQ_GOTO:   n_step = ctl.target;
            SEQ_BRANCH: n_step = cond_true ? ctl.target : t_step'(r_step + 4'd1);
            SEQ_WAIT:   n_step = cond_true ? ctl.target : r_step;
            default:    n_step = STEP_FETCH;
        endcase
    end

    // control word out
    always_comb begin
        o_ctl = ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### design/dssm_dp.sv
// datapath: item latch, stack counts, pointer, storage array and result
module dssm_dp import dssm_pkg::*; #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    input  logic                          i_in_valid,
    input  logic                          i_action,
    input  logic                          i_stack_select,
    input  logic signed [VALUE_WIDTH-1:0] i_push_value,
    input  logic                          i_out_free,
    output t_flags                        o_flags,
    output t_result                       o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                  r_action;
    logic                  r_sel;
    logic [DATA_WIDTH-1:0] r_value;
    logic [CW-1:0]         r_first;
    logic [CW-1:0]         r_total;
    logic [CW-1:0]         r_ptr;
    logic [CW-1:0]         n_ptr;
    logic [DATA_WIDTH-1:0] r_rd_data;
    t_result               r_res;
    t_result               n_res;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic                  accept;
    logic [CW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data;

    assign accept = i_in_valid && i_ctl.in_ready;

    // item latch, values kept at storage width
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_sel    <= i_stack_select;
            r_value  <= DATA_WIDTH'(i_push_value);
        end
    end

    // counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_total <= '0;
        end else if (i_ctl.cnt_push) begin
            r_total <= r_total + CW'(1);
            if (r_sel == SEL_LOWER) begin
                r_first <= r_first + CW'(1);
            end
        end
    end

    // pointer
    always_comb begin
        case (i_ctl.ptr_op)
            PTR_HOLD:  n_ptr = r_ptr;
            PTR_TOTAL: n_ptr = r_total;
            PTR_DEC:   n_ptr = r_ptr - CW'(1);
            PTR_TOP:   n_ptr = (r_sel == SEL_UPPER) ? r_total - CW'(1) : r_first - CW'(1);
            default:   n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    // storage access
    always_comb begin
        case (i_ctl.rd_op)
            RD_PTR:    rd_addr = r_ptr;
            RD_PTR_M1: rd_addr = r_ptr - CW'(1);
            RD_PTR_M2: rd_addr = r_ptr - CW'(2);
            default:   rd_addr = r_ptr;
        endcase
    end

    // reads that run off the bottom of the array are dropped
    assign rd_en   = (i_ctl.rd_op != RD_NONE) && (rd_addr < CW'(DEPTH));
    assign wr_en   = (i_ctl.wr_op != WR_NONE);
    assign wr_data = (i_ctl.wr_op == WR_SHIFT) ? r_rd_data : r_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_ptr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr[AW-1:0]];
        end
    end

    // result word
    always_comb begin
        case (i_ctl.res_op)
            RES_HOLD:     n_res = r_res;
            RES_PUSH_OK:  n_res = '{value: '0, status: ST_OK};
            RES_OVERFLOW: n_res = '{value: '0, status: ST_OVERFLOW};
            RES_EMPTY:    n_res = '{value: '1, status: ST_EMPTY};
            RES_READ:     n_res = '{value: VALUE_WIDTH'($signed(r_rd_data)), status: ST_OK};
            default:      n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;

    always_comb begin
        o_flags.accept     = accept;
        o_flags.peek       = (r_action == ACT_PEEK);
        o_flags.full       = (r_total >= CW'(DEPTH)) || (r_first > r_total);
        o_flags.upper      = (r_sel == SEL_UPPER);
        o_flags.at_first   = (r_ptr == r_first);
        o_flags.shift_done = ((r_ptr - CW'(1)) == r_first);
        o_flags.empty      = (r_sel == SEL_UPPER) ? (r_total <= r_first)
                                                  : (r_first == '0);
        o_flags.out_free   = i_out_free;
    end

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first <= r_total)
        else $error("lower count above total count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(DEPTH))
        else $error("total count beyond depth");

    a_shift_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr_op == WR_SHIFT) |-> (r_ptr > r_first) && (r_ptr <= r_total))
        else $error("shift write outside the upper stack");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_total < CW'(DEPTH)))
        else $error("write into a full array");

endmodule

### tb/dual_stack_shared_memory_test.sv
// self-checking testbench for the two-stack shared memory with random handshakes
`timescale 1ns / 100ps

module dual_stack_shared_memory_test;
    import dssm_pkg::*;

    localparam int DEPTH          = 128;
    localparam int DATA_WIDTH     = 32;
    localparam int RANDOM_ITEMS   = 950;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_AT     = 150;   // accepted requests before the long sink stall
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 160;   // longer than the slowest idle-to-idle request

    // one pending request; wait_idle holds it back until nothing is outstanding
    typedef struct {
        logic                   action;
        logic                   stack_select;
        logic [VALUE_WIDTH-1:0] push_value;
        bit                     wait_idle;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    dssm_in_if  req_ch ();
    dssm_out_if rsp_ch ();

    dual_stack_shared_memory #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    // shadow copy of the shared array and its two fill levels
    logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
    int                    lower_words;
    int                    used_words;

    t_request request_queue [$];
    t_result  expected_results [$];
    t_request current_request;

    int total_requests;
    int accepted_requests;
    int mismatch_count;
    int cycle_count;

    // sender burst shaping
    int burst_left;
    int gap_left;

    // receiver stall pattern
    int  ready_mode;
    int  mode_cycles;
    int  holdoff_left;
    bit  holdoff_done;

    task automatic report_mismatch(input string msg);
        $display("error at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // apply one request to the shadow state and return the result it must give
    function automatic t_result predict_stack_result(input t_request rq);
        t_result r;
        r.value  = '0;
        r.status = ST_OK;
        if (rq.action == ACT_PUSH) begin
            if (used_words >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else if (rq.stack_select == SEL_LOWER) begin
                // upper stack moves up one slot, highest word first
                for (int k = used_words; k > lower_words; k--)
                    shadow_mem[k] = shadow_mem[k-1];
                shadow_mem[lower_words] = rq.push_value;
                lower_words++;
                used_words++;
            end else begin
                shadow_mem[used_words] = rq.push_value;
                used_words++;
            end
        end else if (rq.stack_select == SEL_LOWER) begin
            if (lower_words == 0) begin
                r.status = ST_EMPTY;
                r.value  = '1;
            end else begin
                r.value = shadow_mem[lower_words-1];
            end
        end else begin
            // emptiness of the upper stack is judged on its own words only
            if (used_words <= lower_words) begin
                r.status = ST_EMPTY;
                r.value  = '1;
            end else begin
                r.value = shadow_mem[used_words-1];
            end
        end
        return r;
    endfunction

    task automatic queue_request(input logic act, input logic sel,
                                 input logic [VALUE_WIDTH-1:0] val, input bit hold);
        t_request rq;
        rq.action       = act;
        rq.stack_select = sel;
        rq.push_value   = val;
        rq.wait_idle    = hold;
        request_queue.push_back(rq);
        total_requests++;
    endtask

    // clock, single reset pulse and known levels on every input from time zero
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_PUSH;
        req_ch.stack_select = SEL_LOWER;
        req_ch.push_value   = '0;
        rsp_ch.ready        = 1'b0;
        fork
            forever #10 i_clk = ~i_clk;
            begin
                repeat (6) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    // stimulus: directed corner cases first, then random traffic
    initial begin
        total_requests = 0;

        // both stacks empty
        queue_request(ACT_PEEK, SEL_LOWER, 32'h0000_0000, 1'b0);
        queue_request(ACT_PEEK, SEL_UPPER, 32'hffff_ffff, 1'b0);
        // upper stack alone, lower still empty
        queue_request(ACT_PUSH, SEL_UPPER, 32'h7fff_ffff, 1'b0);
        queue_request(ACT_PEEK, SEL_LOWER, 32'h1234_5678, 1'b0);
        queue_request(ACT_PEEK, SEL_UPPER, 32'h0000_0000, 1'b0);
        // lower push with one upper word to move
        queue_request(ACT_PUSH, SEL_LOWER, 32'h8000_0000, 1'b0);
        queue_request(ACT_PEEK, SEL_LOWER, 32'hffff_ffff, 1'b0);
        queue_request(ACT_PEEK, SEL_UPPER, 32'h0000_0000, 1'b0);
        queue_request(ACT_PUSH, SEL_LOWER, 32'hffff_ffff, 1'b0);
        queue_request(ACT_PUSH, SEL_UPPER, 32'h0000_0000, 1'b0);
        queue_request(ACT_PUSH, SEL_UPPER, 32'h5555_5555, 1'b0);
        // lower push moving several upper words
        queue_request(ACT_PUSH, SEL_LOWER, 32'haaaa_aaaa, 1'b0);
        queue_request(ACT_PEEK, SEL_LOWER, 32'h0000_0000, 1'b0);
        queue_request(ACT_PEEK, SEL_UPPER, 32'hffff_ffff, 1'b0);
        queue_request(ACT_PUSH, SEL_LOWER, 32'h0000_0001, 1'b0);
        queue_request(ACT_PEEK, SEL_LOWER, 32'h8000_0000, 1'b0);
        queue_request(ACT_PEEK, SEL_UPPER, 32'h7fff_ffff, 1'b0);

        // random part; about a third pushes so the array fills part way through
        // and the rest exercises overflow and peeks at a full array
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_request(($urandom_range(99) < 35) ? ACT_PUSH : ACT_PEEK,
                          1'($urandom_range(1)), $urandom,
                          (n == 300) || (n == 700));
        end

        @(posedge i_rst_n);
        // poll away from the active edge so counters are settled
        while (accepted_requests < total_requests || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid      <= 1'b0;
            accepted_requests  = 0;
            burst_left         = 0;
            gap_left           = 0;
        end else begin
            // a transaction at this edge: predict it before anything else moves
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(predict_stack_result(current_request));
                accepted_requests++;
            end
            // valid stays up until the current request is taken
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (request_queue.size() == 0 ||
                             (request_queue[0].wait_idle && expected_results.size() != 0)) begin
                    // nothing left, or a full drain is wanted before this one
                    req_ch.valid <= 1'b0;
                end else begin
                    current_request            = request_queue.pop_front();
                    req_ch.valid              <= 1'b1;
                    req_ch.action             <= current_request.action;
                    req_ch.stack_select       <= current_request.stack_select;
                    req_ch.push_value         <= current_request.push_value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // a long unbroken stretch now and then, otherwise short bursts
                        burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30)
                                                              : $urandom_range(8);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
        end
    end

    // result sink: random ready pattern, redrawn whenever the mode counter wraps, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            ready_mode    = 0;
            mode_cycles   = 0;
            holdoff_left  = 0;
            holdoff_done  = 1'b0;
        end else begin
            if (!holdoff_done && accepted_requests >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            mode_cycles++;
            if (mode_cycles == 64) begin
                mode_cycles = 0;
                ready_mode  = $urandom_range(3);
            end
            if (holdoff_left > 0) begin
                // block fills: one result held, next request stuck in its input
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(1) == 0);
                    2:       rsp_ch.ready <= (mode_cycles % 3 == 0);
                    default: rsp_ch.ready <= ($urandom_range(99) < 85);
                endcase
            end
        end
    end

    // result monitor: each transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: value %0d status %0d",
                                          rsp_ch.read_value, rsp_ch.status));
            end else begin
                want = expected_results.pop_front();
                if (rsp_ch.read_value !== want.value)
                    report_mismatch($sformatf("read_value %0d, predicted %0d",
                                              rsp_ch.read_value, $signed(want.value)));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              rsp_ch.status, want.status));
            end
        end
    end

    // watchdog
    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            report_mismatch($sformatf("timeout with %0d of %0d requests taken, %0d results due",
                                      accepted_requests, total_requests,
                                      expected_results.size()));
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
